@@ hw/rtl/tws_pkg.sv @@
// Shared types and constants of the three-wire serial master.
package tws_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] BIT_READ_START = 5'(BITS_PER_BYTE);
    localparam logic [4:0] BIT_LAST       = 5'(2 * BITS_PER_BYTE);
    localparam logic [7:0] HALF_RESET     = 8'd1;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREP,
        PH_LOW,
        PH_HIGH,
        PH_FINISH
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] command_byte;
        logic [7:0] write_data;
        logic       io_sample;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_port_t;

endpackage

@@ hw/rtl/tws_front.sv @@
// Front end: accepts input requests and classifies their command codes.
module tws_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                queue_full,
    output tws_pkg::queue_port_t push
);
    import tws_pkg::*;

    kind_t kind;

    always_comb begin
        unique case (s_tuser)
            CMD_WRITE: kind = KIND_WRITE;
            CMD_READ:  kind = KIND_READ;
            default:   kind = KIND_TICK;
        endcase
    end

    assign s_tready               = !queue_full;
    assign push.valid             = s_tvalid && !queue_full;
    assign push.item.kind         = kind;
    assign push.item.command_byte = s_tdata[7:0];
    assign push.item.write_data   = s_tdata[15:8];
    assign push.item.io_sample    = s_tdata[16];

endmodule

@@ hw/rtl/tws_queue.sv @@
// Short queue of classified requests between the front and back ends.
module tws_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tws_pkg::queue_port_t push,
    output logic                 full,
    input  logic                 pop,
    output tws_pkg::queue_port_t head
);
    import tws_pkg::*;

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

@@ hw/rtl/tws_back.sv @@
// Back end: serial transfer sequencer with its registered result stage.
module tws_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  tws_pkg::queue_port_t head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata
);
    import tws_pkg::*;

    logic [7:0]  half_reg;
    phase_t      phase_reg, phase_next;
    logic [4:0]  bit_reg, bit_next, bit_inc;
    logic [15:0] out_shift_reg, out_shift_next;
    logic [7:0]  in_shift_reg, in_shift_next;
    logic [7:0]  tick_reg, tick_next;
    logic        is_read_reg, is_read_next;
    logic        clock_reg, clock_next;
    logic        enable_reg, enable_next;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    logic [7:0]  half_eff;
    logic [8:0]  tick_inc;
    logic        elapsed;
    logic        done;
    logic        drive;
    logic        dout;
    logic        shifting;

    assign pop      = head.valid && (!m_tvalid_reg || m_tready);
    assign half_eff = (half_reg == '0) ? HALF_RESET : half_reg;
    assign tick_inc = {1'b0, tick_reg} + 9'd1;
    assign elapsed  = (tick_inc >= {1'b0, half_eff});
    assign bit_inc  = bit_reg + 5'd1;

    always_comb begin
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;
        tick_next      = elapsed ? '0 : tick_inc[7:0];
        is_read_next   = is_read_reg;
        clock_next     = clock_reg;
        enable_next    = enable_reg;
        done           = 1'b0;
        unique case (phase_reg)
            PH_PREP: begin
                if (elapsed) begin
                    enable_next = 1'b1;
                    phase_next  = PH_LOW;
                end
            end
            PH_LOW: begin
                if (elapsed) begin
                    if (is_read_reg && bit_reg >= BIT_READ_START) begin
                        in_shift_next = {head.item.io_sample, in_shift_reg[7:1]};
                    end
                    clock_next = 1'b1;
                    phase_next = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (elapsed) begin
                    clock_next = 1'b0;
                    bit_next   = bit_inc;
                    if (bit_inc >= BIT_LAST) begin
                        enable_next = 1'b0;
                        phase_next  = PH_FINISH;
                    end else begin
                        phase_next = PH_LOW;
                    end
                end
            end
            PH_FINISH: begin
                if (elapsed) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = tick_reg;
                if (head.item.kind == KIND_WRITE || head.item.kind == KIND_READ) begin
                    out_shift_next = {head.item.write_data, head.item.command_byte};
                    is_read_next   = (head.item.kind == KIND_READ);
                    bit_next       = '0;
                    tick_next      = '0;
                    enable_next    = 1'b0;
                    clock_next     = 1'b0;
                    phase_next     = PH_PREP;
                end
            end
        endcase

        shifting = (phase_next == PH_LOW) || (phase_next == PH_HIGH);
        drive    = (phase_next == PH_PREP) ||
                   (shifting && !(is_read_next && bit_next >= BIT_READ_START));
        dout     = drive && shifting && out_shift_next[bit_next[3:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg      <= HALF_RESET;
            phase_reg     <= PH_IDLE;
            bit_reg       <= '0;
            out_shift_reg <= '0;
            in_shift_reg  <= '0;
            tick_reg      <= '0;
            is_read_reg   <= 1'b0;
            clock_reg     <= 1'b0;
            enable_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                half_reg <= cfg_wr_data;
            end
            if (pop) begin
                phase_reg     <= phase_next;
                bit_reg       <= bit_next;
                out_shift_reg <= out_shift_next;
                in_shift_reg  <= in_shift_next;
                tick_reg      <= tick_next;
                is_read_reg   <= is_read_next;
                clock_reg     <= clock_next;
                enable_reg    <= enable_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= {2'b00, in_shift_next, done, (phase_next != PH_IDLE),
                            drive, dout, clock_next, enable_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hw/rtl/three_wire_serial_master_top.sv @@
// Top level of the three-wire serial master: front end, request queue and sequencer.
// An accepted request is written to the queue, then its result to the result register.
// Throughput: one request per cycle; the sequencer advances once per queued request.
// A stalled result register holds the sequencer while the two-entry queue still accepts.
// Reset: synchronous, active low; empties the queue, idles the sequencer, half period 1.
module three_wire_serial_master_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // command_byte, write_data, io_sample, zero padding
    input  logic [1:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // enable_pin, clock_pin, data_out, data_drive,
                                  // busy_res, done_res, read_byte, zero padding
);
    import tws_pkg::*;

    queue_port_t push;
    queue_port_t head;
    logic        queue_full;
    logic        pop;

    tws_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push)
    );

    tws_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .pop     (pop),
        .head    (head)
    );

    tws_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ hw/rtl/tws_checker.sv @@
// Port-level checker of the three-wire serial master and its bind.
module tws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> !m_tdata[4] && !m_tdata[0] && !m_tdata[1])
        else $error("done shown while transfer still active");

    a_dout_driven: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[3] && m_tdata[4])
        else $error("data level without drive");

    a_clock_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && m_tdata[4])
        else $error("serial clock high with enable low");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind three_wire_serial_master_top tws_checker u_tws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
